[design/dulr_pkg.sv]
// Shared types and constants for the daily usage ring logger.
package dulr_pkg;

    localparam int AMOUNT_W    = 20;
    localparam int YEAR_W      = 7;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int TOTAL_W     = 16;
    localparam int OUT_IDX_W   = 3;
    localparam int QUOT_W      = 17;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 23;
    localparam int PROD_W      = AMOUNT_W + RECIP_W;

    localparam logic [RECIP_W-1:0]   RECIP_TENTH = 20'd838861;
    localparam logic [QUOT_W-1:0]    QUOT_MAX    = 17'd104857;
    localparam logic [TOTAL_W-1:0]   LIMIT_RESET = 16'd60000;
    localparam logic [TOTAL_W-1:0]   TOTAL_MAX   = 16'hFFFF;

    localparam logic REG_USAGE_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EVAL,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] usage;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

[design/dulr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dulr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/dulr_div10.sv]
// Divide-by-ten unit that multiplies the amount by a scaled reciprocal of ten in one registered step.
module dulr_div10 (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [dulr_pkg::AMOUNT_W-1:0]   dividend,
    output logic                            done,
    output logic [dulr_pkg::QUOT_W-1:0]     quotient
);

    logic                          done_reg, done_next;
    logic [dulr_pkg::QUOT_W-1:0]   quot_reg, quot_next;
    logic [dulr_pkg::PROD_W-1:0]   product;

    always_comb begin
        product   = {{dulr_pkg::RECIP_W{1'b0}}, dividend}
                    * {{dulr_pkg::AMOUNT_W{1'b0}}, dulr_pkg::RECIP_TENTH};
        done_next = start;
        quot_next = quot_reg;
        if (start) begin
            quot_next = product[dulr_pkg::RECIP_SHIFT +: dulr_pkg::QUOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
        end
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

    property p_done_after_start;
        @(posedge aclk) disable iff (!aresetn) done_reg |-> $past(start);
    endproperty
    a_done_after_start: assert property (p_done_after_start)
        else $error("divider finished without a start");

    property p_quot_range;
        @(posedge aclk) disable iff (!aresetn) done_reg |-> (quot_reg <= dulr_pkg::QUOT_MAX);
    endproperty
    a_quot_range: assert property (p_quot_range)
        else $error("divider quotient out of range");

    property p_done_single;
        @(posedge aclk) disable iff (!aresetn) done_reg |=> !done_reg;
    endproperty
    a_done_single: assert property (p_done_single)
        else $error("divider finished twice in a row");

endmodule

[design/daily_usage_ring_logger.sv]
// Top level of the daily usage ring logger: sequencer, ring pointers, config port and output register.
//
//   channel   ports            beat content
//   input     s_tvalid/tready  tdata: amount_ml, year, month, day_of_month
//   output    m_tvalid/tready  tdata: entry_index, oldest_index, entry_count, entry_total;
//                              tuser: new_day
//   config    APB psel/penable register 0 usage_limit at address 0
//
// An event goes from acceptance through ST_DIV for the registered multiply by the reciprocal of ten,
// ST_EVAL to evaluate the stored entry and ST_COMMIT to commit and load the output beat.
// The block takes a new beat only when the sequencer is idle, not while an event is in flight.
// A commit waits while a previous output beat is still held. Reset clears all
// pointers and the per-entry valid bits, so no clearing pass over the ring is needed.
module daily_usage_ring_logger #(
    parameter int ENTRIES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // amount_ml[19:0], year[26:20], month[30:27], day_of_month[35:31]
    input  logic [39:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_index[2:0], oldest_index[5:3], entry_count[8:6], entry_total[24:9]
    output logic [31:0] m_tdata,
    // new_day[0]
    output logic        m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PTR_W = $clog2(ENTRIES);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ENTRIES - 1);

    localparam int YEAR_LO  = dulr_pkg::AMOUNT_W;
    localparam int MONTH_LO = YEAR_LO + dulr_pkg::YEAR_W;
    localparam int DAY_LO   = MONTH_LO + dulr_pkg::MONTH_W;

    dulr_pkg::state_t state_reg, state_next;

    logic [PTR_W-1:0]             wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]             oldest_reg, oldest_next;
    logic [PTR_W-1:0]             count_reg, count_next;
    logic [ENTRIES-1:0]           valid_reg, valid_next;
    logic                         rd_valid_reg;
    logic [dulr_pkg::TOTAL_W-1:0] limit_reg;

    logic [dulr_pkg::YEAR_W-1:0]  year_reg;
    logic [dulr_pkg::MONTH_W-1:0] month_reg;
    logic [dulr_pkg::DAY_W-1:0]   day_reg;

    logic                         moved_reg, moved_next;
    logic [PTR_W-1:0]             ptr_new_reg, ptr_new_next;
    logic [dulr_pkg::TOTAL_W-1:0] base_reg, base_next;

    logic [31:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;
    logic        m_tvalid_reg, m_tvalid_next;

    logic                          accept;
    logic                          div_done;
    logic [dulr_pkg::QUOT_W-1:0]   quot;
    logic [dulr_pkg::ENTRY_W-1:0]  rd_raw;
    dulr_pkg::entry_t              stored;
    dulr_pkg::entry_t              wr_entry;
    logic                          ram_we;
    logic                          out_free;
    logic                          unset;
    logic                          differs;
    logic [dulr_pkg::QUOT_W:0]     sum;
    logic [dulr_pkg::TOTAL_W-1:0]  total;
    logic                          cfg_write;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == PTR_LAST) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == dulr_pkg::ST_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == dulr_pkg::REG_USAGE_LIMIT) ? 32'(limit_reg) : 32'd0;

    dulr_div10 u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .dividend (s_tdata[dulr_pkg::AMOUNT_W-1:0]),
        .done     (div_done),
        .quotient (quot)
    );

    dulr_ram #(
        .WIDTH (dulr_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ptr_new_reg),
        .wdata (wr_entry),
        .raddr (wr_ptr_reg),
        .rdata (rd_raw)
    );

    always_comb begin
        stored  = rd_valid_reg ? dulr_pkg::entry_t'(rd_raw) : '0;
        unset   = (stored.year == '0) && (stored.month == '0) && (stored.day == '0);
        differs = (stored.year != year_reg) || (stored.month != month_reg)
                  || (stored.day != day_reg);

        sum   = {2'b00, base_reg} + {1'b0, quot};
        total = base_reg;
        if (base_reg < limit_reg) begin
            total = (sum > (dulr_pkg::QUOT_W+1)'(dulr_pkg::TOTAL_MAX))
                    ? dulr_pkg::TOTAL_MAX : dulr_pkg::TOTAL_W'(sum);
        end

        wr_entry.usage = total;
        wr_entry.day   = day_reg;
        wr_entry.month = month_reg;
        wr_entry.year  = year_reg;

        state_next    = state_reg;
        wr_ptr_next   = wr_ptr_reg;
        oldest_next   = oldest_reg;
        count_next    = count_reg;
        valid_next    = valid_reg;
        moved_next    = moved_reg;
        ptr_new_next  = ptr_new_reg;
        base_next     = base_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ram_we        = 1'b0;

        case (state_reg)
            dulr_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = dulr_pkg::ST_DIV;
                end
            end
            dulr_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = dulr_pkg::ST_EVAL;
                end
            end
            dulr_pkg::ST_EVAL: begin
                moved_next   = !unset && differs;
                ptr_new_next = (!unset && differs) ? ring_next(wr_ptr_reg) : wr_ptr_reg;
                base_next    = (!unset && !differs) ? stored.usage : '0;
                state_next   = dulr_pkg::ST_COMMIT;
            end
            dulr_pkg::ST_COMMIT: begin
                if (out_free) begin
                    ram_we                  = 1'b1;
                    valid_next[ptr_new_reg] = 1'b1;
                    wr_ptr_next             = ptr_new_reg;
                    if (moved_reg) begin
                        if (ptr_new_reg == oldest_reg) begin
                            oldest_next = ring_next(oldest_reg);
                        end
                        if (count_reg != PTR_LAST) begin
                            count_next = PTR_W'(count_reg + 1'b1);
                        end
                    end
                    m_tdata_next = {7'd0, total,
                                    dulr_pkg::OUT_IDX_W'(count_next),
                                    dulr_pkg::OUT_IDX_W'(oldest_next),
                                    dulr_pkg::OUT_IDX_W'(ptr_new_reg)};
                    m_tuser_next  = moved_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = dulr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dulr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dulr_pkg::ST_IDLE;
            wr_ptr_reg   <= '0;
            oldest_reg   <= '0;
            count_reg    <= '0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            limit_reg    <= dulr_pkg::LIMIT_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wr_ptr_reg   <= wr_ptr_next;
            oldest_reg   <= oldest_next;
            count_reg    <= count_next;
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[wr_ptr_reg];
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_write && (paddr[2] == dulr_pkg::REG_USAGE_LIMIT)) begin
                limit_reg <= pwdata[dulr_pkg::TOTAL_W-1:0];
            end
        end
        if (accept) begin
            year_reg  <= s_tdata[YEAR_LO +: dulr_pkg::YEAR_W];
            month_reg <= s_tdata[MONTH_LO +: dulr_pkg::MONTH_W];
            day_reg   <= s_tdata[DAY_LO +: dulr_pkg::DAY_W];
        end
        moved_reg   <= moved_next;
        ptr_new_reg <= ptr_new_next;
        base_reg    <= base_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tvalid = m_tvalid_reg;

    property p_count_bound;
        @(posedge aclk) disable iff (!aresetn) count_reg <= PTR_LAST;
    endproperty
    a_count_bound: assert property (p_count_bound)
        else $error("day-change count passed its limit");

    property p_oldest_apart;
        @(posedge aclk) disable iff (!aresetn) (count_reg != '0) |-> (wr_ptr_reg != oldest_reg);
    endproperty
    a_oldest_apart: assert property (p_oldest_apart)
        else $error("write pointer met the oldest pointer after a day change");

    property p_divide_only_when_busy;
        @(posedge aclk) disable iff (!aresetn) div_done |-> (state_reg == dulr_pkg::ST_DIV);
    endproperty
    a_divide_only_when_busy: assert property (p_divide_only_when_busy)
        else $error("divider finished outside the divide phase");

    property p_commit_marks_valid;
        @(posedge aclk) disable iff (!aresetn) ram_we |=> valid_reg[$past(ptr_new_reg)];
    endproperty
    a_commit_marks_valid: assert property (p_commit_marks_valid)
        else $error("written ring entry not marked valid");

endmodule

[tb/sv/daily_usage_ring_logger_checker.sv]
// Checker for the daily usage ring logger: tracks the day ring and compares every output beat.
module daily_usage_ring_logger_checker
    import dulr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [39:0] s_tdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          outstanding
);

    localparam int RING_DEPTH = 8;
    localparam int unsigned ML_PER_UNIT = 10;
    localparam logic [2:0] LIMIT_ADDR = {REG_USAGE_LIMIT, 2'b00};

    typedef struct packed {
        logic [OUT_IDX_W-1:0] entry_index;
        logic [OUT_IDX_W-1:0] oldest_index;
        logic [OUT_IDX_W-1:0] entry_count;
        logic [TOTAL_W-1:0]   entry_total;
        logic                 new_day;
    } day_report_t;

    day_report_t        pending_reports[$];
    logic [YEAR_W-1:0]  day_year  [RING_DEPTH];
    logic [MONTH_W-1:0] day_month [RING_DEPTH];
    logic [DAY_W-1:0]   day_date  [RING_DEPTH];
    logic [TOTAL_W-1:0] day_usage [RING_DEPTH];
    logic [2:0]         head_pos;
    logic [2:0]         oldest_pos;
    logic [2:0]         day_changes;
    logic [TOTAL_W-1:0] limit_now;
    int                 failures;

    assign mismatches = failures;

    function automatic logic [2:0] ring_step(logic [2:0] pos);
        return (pos == RING_DEPTH - 1) ? 3'd0 : pos + 3'd1;
    endfunction

    function automatic day_report_t log_dispense(logic [39:0] beat);
        logic [AMOUNT_W-1:0] amount;
        logic [YEAR_W-1:0]   yr;
        logic [MONTH_W-1:0]  mo;
        logic [DAY_W-1:0]    dy;
        logic [2:0]          pos;
        int unsigned         sum;
        day_report_t         report;
        amount = beat[19:0];
        yr = beat[26:20];
        mo = beat[30:27];
        dy = beat[35:31];
        report.new_day = 1'b0;
        pos = head_pos;
        if (day_year[pos] == '0 && day_month[pos] == '0 && day_date[pos] == '0) begin
            day_year[pos] = yr;
            day_month[pos] = mo;
            day_date[pos] = dy;
            day_usage[pos] = '0;
        end else if (yr != day_year[pos] || mo != day_month[pos] || dy != day_date[pos]) begin
            pos = ring_step(pos);
            if (pos == oldest_pos) begin
                oldest_pos = ring_step(oldest_pos);
            end
            if (day_changes != RING_DEPTH - 1) begin
                day_changes = day_changes + 3'd1;
            end
            day_year[pos] = yr;
            day_month[pos] = mo;
            day_date[pos] = dy;
            day_usage[pos] = '0;
            report.new_day = 1'b1;
        end
        head_pos = pos;
        sum = 32'(day_usage[pos]);
        if (sum < 32'(limit_now)) begin
            sum = sum + 32'(amount) / ML_PER_UNIT;
            if (sum > 32'(TOTAL_MAX)) begin
                sum = 32'(TOTAL_MAX);
            end
            day_usage[pos] = sum[TOTAL_W-1:0];
        end
        report.entry_index = pos;
        report.oldest_index = oldest_pos;
        report.entry_count = day_changes;
        report.entry_total = sum[TOTAL_W-1:0];
        return report;
    endfunction

    always @(posedge aclk) begin
        day_report_t got;
        day_report_t want;
        if (!aresetn) begin
            for (int i = 0; i < RING_DEPTH; i++) begin
                day_year[i] = '0;
                day_month[i] = '0;
                day_date[i] = '0;
                day_usage[i] = '0;
            end
            head_pos = '0;
            oldest_pos = '0;
            day_changes = '0;
            limit_now = LIMIT_RESET;
            pending_reports.delete();
            failures = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR) begin
                limit_now = pwdata[TOTAL_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                pending_reports.push_back(log_dispense(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got.entry_index = m_tdata[2:0];
                got.oldest_index = m_tdata[5:3];
                got.entry_count = m_tdata[8:6];
                got.entry_total = m_tdata[24:9];
                got.new_day = m_tuser;
                if (pending_reports.size() == 0) begin
                    if (failures < 10) begin
                        $display("Unexpected beat: index %0d oldest %0d count %0d",
                                 got.entry_index, got.oldest_index, got.entry_count);
                        $display("    total %0d new_day %0d", got.entry_total, got.new_day);
                    end
                    failures++;
                end else begin
                    want = pending_reports.pop_front();
                    if (got.entry_index !== want.entry_index ||
                        got.oldest_index !== want.oldest_index ||
                        got.entry_count !== want.entry_count ||
                        got.entry_total !== want.entry_total ||
                        got.new_day !== want.new_day) begin
                        if (failures < 10) begin
                            $display("Mismatch (expected/actual): index %0d/%0d oldest %0d/%0d",
                                     want.entry_index, got.entry_index,
                                     want.oldest_index, got.oldest_index);
                            $display("    count %0d/%0d total %0d/%0d new_day %0d/%0d",
                                     want.entry_count, got.entry_count,
                                     want.entry_total, got.entry_total,
                                     want.new_day, got.new_day);
                        end
                        failures++;
                    end
                end
            end
        end
        outstanding = pending_reports.size();
    end

endmodule

[tb/sv/daily_usage_ring_logger_test.sv]
// Top of the daily usage ring logger testbench: clock, reset, stimulus and verdict.
module daily_usage_ring_logger_test;
    import dulr_pkg::*;

    localparam logic [2:0] LIMIT_ADDR = {REG_USAGE_LIMIT, 2'b00};
    localparam logic [2:0] UNUSED_REG_ADDR = {~REG_USAGE_LIMIT, 2'b00};

    logic        aclk;
    logic        aresetn;
    logic [39:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int check_failures;
    int reports_due;
    bit calm;
    bit long_stall_req;

    logic [YEAR_W-1:0]  cur_year;
    logic [MONTH_W-1:0] cur_month;
    logic [DAY_W-1:0]   cur_day;

    daily_usage_ring_logger DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    daily_usage_ring_logger_checker usage_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .mismatches(check_failures), .outstanding(reports_due)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #5_000_000;
        $display("daily_usage_ring_logger_test: FAIL");
        $finish;
    end

    task automatic send_dispense(input logic [AMOUNT_W-1:0] amount, input logic [YEAR_W-1:0] yr,
                                 input logic [MONTH_W-1:0] mo, input logic [DAY_W-1:0] dy);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 14) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata = {4'b0, dy, mo, yr, amount};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic random_dispense();
        int unsigned pick;
        logic [AMOUNT_W-1:0] amount;
        pick = $urandom_range(99);
        if (pick >= 94) begin
            cur_year = '0;
            cur_month = '0;
            cur_day = '0;
        end else if (pick >= 88) begin
            cur_year = YEAR_W'($urandom);
            cur_month = MONTH_W'($urandom);
            cur_day = DAY_W'($urandom);
        end else if (pick >= 70) begin
            cur_year = YEAR_W'($urandom_range(99));
            cur_month = MONTH_W'($urandom_range(12, 1));
            cur_day = DAY_W'($urandom_range(31, 1));
        end
        pick = $urandom_range(99);
        if (pick < 60) begin
            amount = AMOUNT_W'($urandom_range(3000));
        end else if (pick < 85) begin
            amount = AMOUNT_W'($urandom_range(60000));
        end else begin
            amount = AMOUNT_W'($urandom);
        end
        send_dispense(amount, cur_year, cur_month, cur_day);
    endtask

    task automatic drain_reports();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (reports_due != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_stall_req) begin
                m_tready = 1'b0;
                repeat (400) @(negedge aclk);
                long_stall_req = 1'b0;
            end else begin
                m_tready = calm || ($urandom_range(99) >= 14);
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        long_stall_req = 1'b0;
        cur_year = 7'd24;
        cur_month = 4'd3;
        cur_day = 5'd1;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // An all-zero date on an unset entry keeps the entry unset and restarts its total.
        send_dispense(20'hFFFFF, 7'd0, 4'd0, 5'd0);
        send_dispense(20'd100, 7'd0, 4'd0, 5'd0);
        send_dispense(20'd0, 7'd99, 4'd12, 5'd31);
        send_dispense(20'd9, 7'd99, 4'd12, 5'd31);
        send_dispense(20'd10, 7'd99, 4'd12, 5'd31);
        send_dispense(20'd600000, 7'd99, 4'd12, 5'd31);
        send_dispense(20'd1000, 7'd99, 4'd12, 5'd31);
        send_dispense(20'hFFFFF, 7'h7F, 4'hF, 5'h1F);
        send_dispense(20'hFFFFF, 7'h7F, 4'hF, 5'h1F);
        for (int i = 1; i <= 10; i++) begin
            send_dispense(20'(i * 1234), 7'd25, 4'd1, 5'(i));
        end
        send_dispense(20'd555, 7'd0, 4'd0, 5'd0);
        send_dispense(20'd19, 7'd1, 4'd1, 5'd1);
        drain_reports();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_reg(LIMIT_ADDR, 32'd0);
                1: write_reg(LIMIT_ADDR, 32'd65535);
                2: write_reg(LIMIT_ADDR, 32'd1);
                3: write_reg(UNUSED_REG_ADDR, $urandom);
                4: write_reg(LIMIT_ADDR, $urandom);
                default: write_reg(LIMIT_ADDR, 32'(LIMIT_RESET));
            endcase
            calm = (phase == 2);
            for (int n = 0; n < 330; n++) begin
                if (phase == 4 && n == 100) begin
                    long_stall_req = 1'b1;
                end
                random_dispense();
            end
            drain_reports();
        end
        calm = 1'b0;

        repeat (30) @(posedge aclk);
        if (check_failures == 0) begin
            $display("daily_usage_ring_logger_test: PASS");
        end else begin
            $display("daily_usage_ring_logger_test: FAIL");
        end
        $finish;
    end

endmodule
